// ===== rtl/core/rlse_pkg.sv =====
// Package for the ridgelet Legendre series evaluator: field widths, fixed-point
// formats, command and controller encodings. No dependencies.
package rlse_pkg;

   localparam int MAX_ORDER_DEF  = 16;
   localparam int NUM_LEVELS_DEF = 4;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 5;
   localparam logic [CFG_W-1:0] CFG_MAX_ORDER_RESET = CFG_W'(16);
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_ORDER = '0;

   // stream payload fields
   localparam int LEVEL_W     = 2;
   localparam int CORD_W      = 5;
   localparam int COEF_W      = 32;
   localparam int VEC_W       = 16;
   localparam int ELEM_W      = 48;
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 48;

   // fixed-point datapath widths
   localparam int DOT_W      = 34;
   localparam int X_W        = 30;
   localparam int P_W        = 32;
   localparam int Q_W        = 32;
   localparam int CP_W       = 36;
   localparam int INV_W      = 22;
   localparam int SUM_W      = 56;
   localparam int FRAC_W     = 28;
   localparam int TERM_SHIFT = 24;
   localparam int ONE_Q28    = 1 << FRAC_W;
   localparam int INV4PI     = 1335088;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CAPTURE,
      OP_DOT,
      OP_READ,
      OP_ROUNDA,
      OP_NUM,
      OP_DIVGO,
      OP_PL,
      OP_PROD,
      OP_CP,
      OP_WEIGHT,
      OP_TERM,
      OP_ACC,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT,
      ST_READ,
      ST_ROUNDA,
      ST_NUM,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_PROD,
      ST_CP,
      ST_WEIGHT,
      ST_TERM,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/rlse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rlse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 68
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rlse_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle, for a small divisor.
// The quotient must fit in QW bits. No dependencies.
module rlse_div #(
   parameter int NW = 40,
   parameter int LW = 5,
   parameter int QW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [LW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CNT_W = $clog2(QW / 2);

   logic [LW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [LW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [LW-1:0]    rem_a, rem_b;
   logic             bit_a, bit_b;

   function automatic logic [LW:0] div_step(input logic [LW-1:0] rem,
                                            input logic          nxt,
                                            input logic [LW-1:0] dvs);
      logic [LW:0] part;
      logic [LW:0] diff;
      part = {rem, nxt};
      diff = part - {1'b0, dvs};
      if (part >= {1'b0, dvs}) begin
         return {1'b1, diff[LW-1:0]};
      end
      return {1'b0, part[LW-1:0]};
   endfunction

   always_comb begin
      {bit_a, rem_a} = div_step(rem_ff, quo_ff[QW-1], dvs_ff);
      {bit_b, rem_b} = div_step(rem_a, quo_ff[QW-2], dvs_ff);
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[QW +: LW];
         quo_in  = dividend[QW-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QW / 2 - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_b;
         quo_in = {quo_ff[QW-3:0], bit_a, bit_b};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/rlse_dp.sv =====
// Datapath: coefficient RAM, dot product and clamp, Legendre recurrence, weighted
// accumulation and output register. Uses rlse_pkg, rlse_ram and rlse_div.
module rlse_dp
   import rlse_pkg::*;
#(
   parameter int MAX_ORDER  = MAX_ORDER_DEF,
   parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [$clog2(MAX_ORDER+1)-1:0] order,
   output dp_status_type            status,
   input  logic [LEVEL_W-1:0]       coef_level,
   input  logic [CORD_W-1:0]        coef_order,
   input  logic signed [COEF_W-1:0] coef_value,
   input  logic signed [VEC_W-1:0]  sample_x,
   input  logic signed [VEC_W-1:0]  sample_y,
   input  logic signed [VEC_W-1:0]  sample_z,
   input  logic signed [VEC_W-1:0]  orient_x,
   input  logic signed [VEC_W-1:0]  orient_y,
   input  logic signed [VEC_W-1:0]  orient_z,
   input  logic [LEVEL_W-1:0]       eval_level,
   output logic signed [ELEM_W-1:0] element_value,
   output logic                     was_clamped
);

   localparam int LW    = $clog2(MAX_ORDER + 1);
   localparam int KW    = LW + 1;
   localparam int DEPTH = NUM_LEVELS * (MAX_ORDER + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int PA_W  = X_W + P_W;
   localparam int PC_W  = COEF_W + P_W;
   localparam int NW    = P_W + KW + 2;
   localparam int WKW   = CP_W + KW + 1;
   localparam int TW    = WKW + INV_W;

   localparam logic signed [DOT_W-1:0] DOT_POS = DOT_W'(ONE_Q28);
   localparam logic signed [DOT_W-1:0] DOT_NEG = DOT_W'(-ONE_Q28);
   localparam logic signed [PA_W-1:0]  HALF_A  = PA_W'(ONE_Q28 / 2);
   localparam logic signed [PC_W-1:0]  HALF_C  = PC_W'(ONE_Q28 / 2);
   localparam logic signed [TW-1:0]    HALF_T  = TW'(1 << (TERM_SHIFT - 1));
   localparam logic signed [INV_W-1:0] INV_S   = INV_W'(INV4PI);
   localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (ELEM_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
   localparam logic signed [P_W-1:0]   P_BOUND = P_W'(ONE_Q28) <<< 1;

   logic signed [VEC_W-1:0]  sx_ff, sy_ff, sz_ff, ox_ff, oy_ff, oz_ff;
   logic signed [VEC_W-1:0]  sx_in, sy_in, sz_in, ox_in, oy_in, oz_in;
   logic [LEVEL_W-1:0]       lvl_ff, lvl_in;
   logic                     lvl_ok_ff, lvl_ok_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic                     clamp_ff, clamp_in;
   logic signed [P_W-1:0]    p_cur_ff, p_cur_in, p_prev_ff, p_prev_in;
   logic signed [P_W-1:0]    pl_ff, pl_in, a_ff, a_in;
   logic signed [PA_W-1:0]   prod_a_ff, prod_a_in;
   logic signed [NW-1:0]     num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic signed [PC_W-1:0]   prod_c_ff, prod_c_in;
   logic signed [CP_W-1:0]   cp_ff, cp_in;
   logic signed [WKW-1:0]    wk_ff, wk_in;
   logic signed [TW-1:0]     prod_t_ff, prod_t_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [ELEM_W-1:0] elem_ff, elem_in;
   logic                     clamped_out_ff, clamped_out_in;

   logic signed [2*VEC_W-1:0] m0, m1, m2;
   logic signed [DOT_W-1:0]   dot;
   logic signed [PA_W-1:0]    rnd_a;
   logic signed [PC_W-1:0]    rnd_c;
   logic signed [TW-1:0]      rnd_t;
   logic [KW-1:0]             k_lo, k_hi;
   logic [LW-1:0]             order_m1;
   logic signed [NW-1:0]      t1, t2;
   logic [NW-1:0]             abs_num, div_dividend;
   logic [Q_W-1:0]            div_quo;
   logic                      div_done;
   logic signed [P_W-1:0]     q_s;
   logic signed [COEF_W-1:0]  psi;
   logic [COEF_W-1:0]         ram_rdata;
   logic                      load_ok;
   logic [AW-1:0]             wr_addr, rd_addr;

   assign load_ok = (int'(coef_level) < NUM_LEVELS) && (int'(coef_order) <= MAX_ORDER);
   assign wr_addr = AW'(int'(coef_level) * (MAX_ORDER + 1) + int'(coef_order));
   assign rd_addr = AW'(int'(lvl_ff) * (MAX_ORDER + 1) + int'(order));

   rlse_ram #(
      .WIDTH (COEF_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.op == OP_LOAD && load_ok),
      .wr_addr (wr_addr),
      .wr_data (coef_value),
      .rd_en   (cmd.op == OP_READ),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   rlse_div #(
      .NW (NW),
      .LW (LW),
      .QW (Q_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIVGO),
      .dividend (div_dividend),
      .divisor  (order),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done = div_done;

   always_comb begin
      m0       = sx_ff * ox_ff;
      m1       = sy_ff * oy_ff;
      m2       = sz_ff * oz_ff;
      dot      = DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
      rnd_a    = prod_a_ff + HALF_A;
      rnd_c    = prod_c_ff + HALF_C;
      rnd_t    = prod_t_ff + HALF_T;
      k_lo     = {order, 1'b0} - KW'(1);
      k_hi     = {order, 1'b1};
      order_m1 = order - LW'(1);
      t1       = $signed({1'b0, k_lo}) * a_ff;
      t2       = $signed({1'b0, order_m1}) * p_prev_ff;
      abs_num  = num_ff[NW-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
      div_dividend = abs_num + NW'(order >> 1);
      q_s      = $signed(div_quo);
      psi      = lvl_ok_ff ? $signed(ram_rdata) : '0;
   end

   always_comb begin
      sx_in = sx_ff;
      sy_in = sy_ff;
      sz_in = sz_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      lvl_in = lvl_ff;
      lvl_ok_in = lvl_ok_ff;
      x_in = x_ff;
      clamp_in = clamp_ff;
      p_cur_in = p_cur_ff;
      p_prev_in = p_prev_ff;
      pl_in = pl_ff;
      a_in = a_ff;
      prod_a_in = prod_a_ff;
      num_in = num_ff;
      neg_in = neg_ff;
      prod_c_in = prod_c_ff;
      cp_in = cp_ff;
      wk_in = wk_ff;
      prod_t_in = prod_t_ff;
      sum_in = sum_ff;
      elem_in = elem_ff;
      clamped_out_in = clamped_out_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            sx_in = sample_x;
            sy_in = sample_y;
            sz_in = sample_z;
            ox_in = orient_x;
            oy_in = orient_y;
            oz_in = orient_z;
            lvl_in = eval_level;
            lvl_ok_in = int'(eval_level) < NUM_LEVELS;
         end
         OP_DOT: begin
            if (dot > DOT_POS) begin
               x_in = X_W'(ONE_Q28);
               clamp_in = 1'b1;
            end else if (dot < DOT_NEG) begin
               x_in = X_W'(-ONE_Q28);
               clamp_in = 1'b1;
            end else begin
               x_in = X_W'(dot);
               clamp_in = 1'b0;
            end
            p_cur_in = P_W'(ONE_Q28);
            p_prev_in = '0;
            sum_in = '0;
         end
         OP_READ: begin
            prod_a_in = x_ff * p_cur_ff;
            if (order == '0) begin
               pl_in = P_W'(ONE_Q28);
            end else begin
               pl_in = P_W'(x_ff);
            end
         end
         OP_ROUNDA: begin
            a_in = P_W'(rnd_a >>> FRAC_W);
         end
         OP_NUM: begin
            num_in = t1 - t2;
         end
         OP_DIVGO: begin
            neg_in = num_ff[NW-1];
         end
         OP_PL: begin
            pl_in = neg_ff ? -q_s : q_s;
         end
         OP_PROD: begin
            prod_c_in = psi * pl_ff;
            if (order != '0) begin
               p_prev_in = p_cur_ff;
               p_cur_in = pl_ff;
            end
         end
         OP_CP: begin
            cp_in = CP_W'(rnd_c >>> FRAC_W);
         end
         OP_WEIGHT: begin
            wk_in = $signed({1'b0, k_hi}) * cp_ff;
         end
         OP_TERM: begin
            prod_t_in = wk_ff * INV_S;
         end
         OP_ACC: begin
            sum_in = sum_ff + SUM_W'(rnd_t >>> TERM_SHIFT);
         end
         OP_OUT: begin
            if (sum_ff > SAT_MAX) begin
               elem_in = ELEM_W'(SAT_MAX);
            end else if (sum_ff < SAT_MIN) begin
               elem_in = ELEM_W'(SAT_MIN);
            end else begin
               elem_in = ELEM_W'(sum_ff);
            end
            clamped_out_in = clamp_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oz_ff <= oz_in;
      lvl_ff <= lvl_in;
      lvl_ok_ff <= lvl_ok_in;
      x_ff <= x_in;
      clamp_ff <= clamp_in;
      p_cur_ff <= p_cur_in;
      p_prev_ff <= p_prev_in;
      pl_ff <= pl_in;
      a_ff <= a_in;
      prod_a_ff <= prod_a_in;
      num_ff <= num_in;
      neg_ff <= neg_in;
      prod_c_ff <= prod_c_in;
      cp_ff <= cp_in;
      wk_ff <= wk_in;
      prod_t_ff <= prod_t_in;
      sum_ff <= sum_in;
      elem_ff <= elem_in;
      clamped_out_ff <= clamped_out_in;
   end

   assign element_value = elem_ff;
   assign was_clamped   = clamped_out_ff;

   a_div_not_immediate: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIVGO) |=> !div_done)
      else $error("divider reported done one cycle after start");

   a_pl_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PROD) |-> (pl_ff <= P_BOUND && pl_ff >= -P_BOUND))
      else $error("Legendre value out of range");

endmodule

// ===== rtl/core/rlse_ctrl.sv =====
// Controller: sequences load and evaluate beats through the datapath, walks
// the Legendre orders and holds the result handshake. Uses rlse_pkg.
module rlse_ctrl
   import rlse_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_cmd,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [CFG_W-1:0]               max_order,
   output dp_cmd_type                     cmd,
   output logic [$clog2(MAX_ORDER+1)-1:0] order,
   input  dp_status_type                  status
);

   localparam int LW = $clog2(MAX_ORDER + 1);

   state_type     state_ff, state_in;
   logic [LW-1:0] order_ff, order_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] last_order;
   logic          out_free;

   assign last_order = (int'(max_order) > MAX_ORDER) ? LW'(MAX_ORDER) : LW'(max_order);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd == CMD_EVAL) begin
               state_in = ST_DOT;
            end
         end
         ST_DOT: state_in = ST_READ;
         ST_READ: begin
            state_in = (order_ff <= LW'(1)) ? ST_PROD : ST_ROUNDA;
         end
         ST_ROUNDA: state_in = ST_NUM;
         ST_NUM: state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (status.div_done) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: state_in = ST_CP;
         ST_CP: state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_TERM;
         ST_TERM: state_in = ST_ACC;
         ST_ACC: begin
            state_in = (order_ff == last_order) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = (req_cmd == CMD_EVAL) ? OP_CAPTURE : OP_LOAD;
            end
         end
         ST_DOT: cmd.op = OP_DOT;
         ST_READ: cmd.op = OP_READ;
         ST_ROUNDA: cmd.op = OP_ROUNDA;
         ST_NUM: cmd.op = OP_NUM;
         ST_DIVGO: cmd.op = OP_DIVGO;
         ST_DIVWAIT: begin
            if (status.div_done) begin
               cmd.op = OP_PL;
            end
         end
         ST_PROD: cmd.op = OP_PROD;
         ST_CP: cmd.op = OP_CP;
         ST_WEIGHT: cmd.op = OP_WEIGHT;
         ST_TERM: cmd.op = OP_TERM;
         ST_ACC: cmd.op = OP_ACC;
         ST_DONE: begin
            if (out_free) begin
               cmd.op = OP_OUT;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   // order counter and result beat
   always_comb begin
      order_in = order_ff;
      if (state_ff == ST_DOT) begin
         order_in = '0;
      end else if (state_ff == ST_ACC && order_ff != last_order) begin
         order_in = order_ff + LW'(1);
      end
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign order     = order_ff;
   assign rsp_valid = rsp_valid_ff;

   a_order_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (order_ff <= last_order))
      else $error("order counter ran past the last order");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_cmd == CMD_EVAL) |=> (state_ff == ST_DOT))
      else $error("accepted evaluate beat did not start the dot product");

endmodule

// ===== rtl/core/ridgelet_legendre_series_eval_top.sv =====
// Ridgelet Legendre series evaluator, top level. Uses rlse_pkg, rlse_ctrl, rlse_dp.
// Load beat: no result. Evaluate beat with n = min(max_order_in_use, MAX_ORDER):
// rsp_tvalid rises once orders 0 to n are summed; orders above one use the divider.
// One evaluation at a time; the next beat is taken while a result waits for rsp_tready.
// Synchronous active-high reset clears control state; coefficient RAM is not cleared.
module ridgelet_legendre_series_eval_top
   import rlse_pkg::*;
#(
   parameter int MAX_ORDER  = MAX_ORDER_DEF,
   parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // coef_level[1:0], coef_order[6:2], coef_value[38:7], sample_x[54:39],
   // sample_y[70:55], sample_z[86:71], orient_x[102:87], orient_y[118:103],
   // orient_z[134:119], eval_level[136:135], zero pad above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // element_value[47:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // was_clamped[0]
   output logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int LW = $clog2(MAX_ORDER + 1);

   logic [CFG_W-1:0]         max_order_ff, max_order_in;
   dp_cmd_type               cmd;
   dp_status_type            status;
   logic [LW-1:0]            order;
   logic signed [ELEM_W-1:0] element_value;
   logic                     was_clamped;
   logic                     reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_ORDER;

   always_comb begin
      max_order_in = max_order_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         max_order_in = csr_pwdata[CFG_W-1:0];
      end
      csr_prdata = reg_sel ? CSR_DATA_W'(max_order_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_order_ff <= CFG_MAX_ORDER_RESET;
      end else begin
         max_order_ff <= max_order_in;
      end
   end

   rlse_ctrl #(
      .MAX_ORDER (MAX_ORDER)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .max_order (max_order_ff),
      .cmd       (cmd),
      .order     (order),
      .status    (status)
   );

   rlse_dp #(
      .MAX_ORDER  (MAX_ORDER),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .order         (order),
      .status        (status),
      .coef_level    (req_tdata[1:0]),
      .coef_order    (req_tdata[6:2]),
      .coef_value    (req_tdata[38:7]),
      .sample_x      (req_tdata[54:39]),
      .sample_y      (req_tdata[70:55]),
      .sample_z      (req_tdata[86:71]),
      .orient_x      (req_tdata[102:87]),
      .orient_y      (req_tdata[118:103]),
      .orient_z      (req_tdata[134:119]),
      .eval_level    (req_tdata[136:135]),
      .element_value (element_value),
      .was_clamped   (was_clamped)
   );

   assign rsp_tdata = RSP_TDATA_W'(element_value);
   assign rsp_tuser = was_clamped;

endmodule

// ===== tb/ridgelet_legendre_series_eval_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ridgelet_legendre_series_eval_top: coefficient loads and
// series evaluations; results checked beat by beat against a Q28/Q16.16 series
// predictor or typed values. Depends on rlse_pkg and the top level RTL only.
module ridgelet_legendre_series_eval_top_test
   import rlse_pkg::*;
();

   localparam int     MAX_ORD    = 16;
   localparam int     LEVELS     = 4;
   localparam longint UNIT_Q28   = longint'(1) << 28;
   localparam longint WEIGHT_Q24 = 1335088;
   localparam longint SUM_MAX    = (longint'(1) << 47) - 1;
   localparam int     SAMPLE_LSB = 39;
   localparam int     ORIENT_LSB = 87;
   localparam int     PHASES     = 10;
   localparam int     PHASE_BEATS = 116;

   typedef struct packed {
      logic [6:0]         pad;
      logic [1:0]         eval_level;
      logic signed [15:0] orient_z;
      logic signed [15:0] orient_y;
      logic signed [15:0] orient_x;
      logic signed [15:0] sample_z;
      logic signed [15:0] sample_y;
      logic signed [15:0] sample_x;
      logic signed [31:0] coef_value;
      logic [4:0]         coef_order;
      logic [1:0]         coef_level;
   } req_payload;

   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              clamped;
   } element_exp;

   typedef struct packed {
      cmd_type    cmd;
      req_payload pl;
      logic       typed;
      element_exp want;
   } beat_row;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   logic signed [31:0] psi_table [LEVELS][MAX_ORD+1];
   logic [CFG_W-1:0]   order_limit = CFG_MAX_ORDER_RESET;
   element_exp         element_q[$];
   beat_row            directed_rows[$];
   int                 errors = 0;
   bit                 calm = 1'b0;
   bit                 want_holdoff = 1'b0;
   bit                 holdoff_done = 1'b0;
   int unsigned        order_plan[PHASES] = '{0, 2, 1, 31, 5, 17, 3, 9, 16, 4};

   ridgelet_legendre_series_eval_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint round_div(input longint num, input longint d);
      if (num >= 0)
         return (num + d / 2) / d;
      return -((-num + d / 2) / d);
   endfunction

   function automatic element_exp predict_element(input req_payload p);
      element_exp r;
      longint     x, prev, cur, pl, a, psi, cp, sum, ll;
      int         n;
      x = longint'($signed(p.sample_x)) * longint'($signed(p.orient_x))
        + longint'($signed(p.sample_y)) * longint'($signed(p.orient_y))
        + longint'($signed(p.sample_z)) * longint'($signed(p.orient_z));
      r.clamped = 1'b0;
      if (x > UNIT_Q28) begin
         x = UNIT_Q28;
         r.clamped = 1'b1;
      end
      if (x < -UNIT_Q28) begin
         x = -UNIT_Q28;
         r.clamped = 1'b1;
      end
      n = (order_limit > MAX_ORD) ? MAX_ORD : int'(order_limit);
      sum = 0;
      prev = 0;
      cur = UNIT_Q28;
      for (int l = 0; l <= n; l++) begin
         ll = l;
         if (l == 0) begin
            pl = UNIT_Q28;
         end else if (l == 1) begin
            pl = x;
         end else begin
            a = round_shift(x * cur, 28);
            pl = round_div((2 * ll - 1) * a - (ll - 1) * prev, ll);
         end
         if (l >= 1) begin
            prev = cur;
            cur = pl;
         end
         psi = longint'(psi_table[p.eval_level][l]);
         cp = round_shift(psi * pl, 28);
         sum += round_shift((2 * ll + 1) * cp * WEIGHT_Q24, 24);
      end
      if (sum > SUM_MAX)
         sum = SUM_MAX;
      if (sum < -SUM_MAX - 1)
         sum = -SUM_MAX - 1;
      r.value = sum[ELEM_W-1:0];
      return r;
   endfunction

   function automatic beat_row random_beat();
      beat_row        r;
      logic [159:0]   bits;
      int unsigned    pick;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = '0;
      r.pl = bits[REQ_TDATA_W-1:0];
      r.pl.pad = '0;
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.cmd = CMD_LOAD;
         if ($urandom_range(9) != 0)
            r.pl.coef_order = 5'($urandom_range(MAX_ORD));
         if ($urandom_range(19) == 0)
            r.pl.coef_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
         r.cmd = CMD_EVAL;
         pick = $urandom_range(99);
         if (pick < 55) begin
            r.pl.sample_x = 16'($urandom_range(18918) - 9459);
            r.pl.sample_y = 16'($urandom_range(18918) - 9459);
            r.pl.sample_z = 16'($urandom_range(18918) - 9459);
            r.pl.orient_x = 16'($urandom_range(18918) - 9459);
            r.pl.orient_y = 16'($urandom_range(18918) - 9459);
            r.pl.orient_z = 16'($urandom_range(18918) - 9459);
         end else if (pick < 75) begin
            r.pl[SAMPLE_LSB +: 48] = '0;
            r.pl[ORIENT_LSB +: 48] = '0;
            r.pl[SAMPLE_LSB + 16 * $urandom_range(2) +: 16] =
               $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            r.pl[ORIENT_LSB + 16 * $urandom_range(2) +: 16] =
               $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         end
      end
      return r;
   endfunction

   task automatic add_load(input int lvl, input int ord, input logic [31:0] v);
      beat_row r;
      r = '0;
      r.cmd = CMD_LOAD;
      r.pl.coef_level = 2'(lvl);
      r.pl.coef_order = 5'(ord);
      r.pl.coef_value = v;
      directed_rows.push_back(r);
   endtask

   task automatic add_eval(input int sx, input int sy, input int sz, input int ox,
                           input int oy, input int oz, input int lvl, input logic typed,
                           input logic [ELEM_W-1:0] v, input logic clamp);
      beat_row r;
      r = '0;
      r.cmd = CMD_EVAL;
      r.pl.sample_x = 16'(sx);
      r.pl.sample_y = 16'(sy);
      r.pl.sample_z = 16'(sz);
      r.pl.orient_x = 16'(ox);
      r.pl.orient_y = 16'(oy);
      r.pl.orient_z = 16'(oz);
      r.pl.eval_level = 2'(lvl);
      r.typed = typed;
      r.want.value = v;
      r.want.clamped = clamp;
      directed_rows.push_back(r);
   endtask

   task automatic send_beat(input beat_row r);
      if (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3) == 0 ? $urandom_range(8, 60) : $urandom_range(1, 3))
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= r.pl;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      if (r.cmd == CMD_LOAD) begin
         if (r.pl.coef_order <= MAX_ORD)
            psi_table[r.pl.coef_level][r.pl.coef_order] = r.pl.coef_value;
      end else begin
         element_q.push_back(r.typed ? r.want : predict_element(r.pl));
      end
   endtask

   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      while (element_q.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_order_limit(input int unsigned v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_MAX_ORDER, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1)
         @(posedge clock);
      order_limit = v[CFG_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1)
         @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(order_limit)) begin
         $display("%0t: max_order_in_use readback expected %0d actual %0d",
                  $time, order_limit, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (want_holdoff && !holdoff_done) begin
            rsp_tready <= 1'b0;
            repeat (800) @(posedge clock);
            holdoff_done = 1'b1;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      element_exp e;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (element_q.size() == 0) begin
            $display("%0t: unexpected beat, actual value %h clamped %b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = element_q.pop_front();
            if (rsp_tdata !== e.value) begin
               $display("%0t: element_value expected %h actual %h",
                        $time, e.value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== e.clamped) begin
               $display("%0t: was_clamped expected %b actual %b",
                        $time, e.clamped, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      beat_row r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_LOAD;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot; level 3 starts all zero
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         for (int ord = 0; ord <= MAX_ORD; ord++) begin
            r = '0;
            r.cmd = CMD_LOAD;
            r.pl.coef_level = 2'(lvl);
            r.pl.coef_order = 5'(ord);
            r.pl.coef_value = (lvl == 3) ? 32'd0 : $urandom;
            send_beat(r);
         end
      end

      add_eval(16384, 0, 0, 16384, 0, 0, 3, 1'b1, '0, 1'b0);
      add_eval(32767, 32767, 32767, 32767, 32767, 32767, 3, 1'b1, '0, 1'b1);
      add_eval(-32768, -32768, -32768, 32767, 32767, 32767, 3, 1'b1, '0, 1'b1);
      add_eval(-32768, -32768, -32768, -32768, -32768, -32768, 3, 1'b1, '0, 1'b1);
      add_eval(0, 0, 0, 0, 0, 0, 3, 1'b1, '0, 1'b0);
      add_eval(-16384, 0, 0, 16384, 0, 0, 3, 1'b1, '0, 1'b0);
      add_eval(16384, 16384, 0, 8192, 8193, 0, 3, 1'b1, '0, 1'b1);
      add_eval(16384, 0, 0, 16384, 0, 0, 0, 1'b0, '0, 1'b0);
      add_eval(0, 16384, 0, 0, -16384, 0, 1, 1'b0, '0, 1'b0);
      add_eval(0, 0, 16384, 16384, 0, 0, 2, 1'b0, '0, 1'b0);
      add_load(0, 0, 32'h7FFF_FFFF);
      add_load(0, 16, 32'h8000_0000);
      add_load(1, 17, 32'h1234_5678);
      add_load(2, 31, 32'hFFFF_FFFF);
      add_eval(16384, 0, 0, 16384, 0, 0, 0, 1'b0, '0, 1'b0);
      add_eval(32767, 32767, 32767, 32767, 32767, 32767, 0, 1'b0, '0, 1'b0);
      add_eval(9459, 9459, 9459, 9459, 9459, 9459, 1, 1'b0, '0, 1'b0);
      add_eval(16384, 0, 0, 16384, 0, 0, 2, 1'b0, '0, 1'b0);
      add_load(3, 5, 32'h0001_0000);
      add_eval(5000, -3000, 7000, 9000, 2000, -4000, 3, 1'b0, '0, 1'b0);
      add_eval(16384, 16384, 0, 8192, 8192, 0, 0, 1'b0, '0, 1'b0);
      add_eval(-9459, 9459, -9459, 9459, 9459, 9459, 1, 1'b0, '0, 1'b0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i]);
      drain(16);

      for (int ph = 0; ph < PHASES; ph++) begin
         set_order_limit(order_plan[ph]);
         calm = (ph == 7);
         if (ph == 1)
            want_holdoff <= 1'b1;
         for (int k = 0; k < PHASE_BEATS; k++)
            send_beat(random_beat());
         drain(16);
      end
      calm = 1'b0;

      drain(500);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rlse_pkg.sv
rtl/core/rlse_ram.sv
rtl/core/rlse_div.sv
rtl/core/rlse_dp.sv
rtl/core/rlse_ctrl.sv
rtl/core/ridgelet_legendre_series_eval_top.sv
tb/ridgelet_legendre_series_eval_top_test.sv
